// ----- hw/rtl/bpa_pkg.sv -----
// bpa_pkg: shared types and constants of the buddy page allocator.
// No dependencies; used by buddy_page_allocator_core and its testbench.
package bpa_pkg;

    localparam int MAX_PAGES_DEF = 1024;
    localparam int CNT_W         = 11;
    localparam int PAGE_W        = 10;
    localparam int LOG_W         = 4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_SPACE  = 2'd1;
    localparam logic [1:0] ST_BAD_SIZE  = 2'd2;
    localparam logic [1:0] ST_BAD_FREE  = 2'd3;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_CHECK,
        S_DOWN_RD,
        S_DOWN_WT,
        S_DOWN_DEC,
        S_FREE_RD,
        S_FREE_WT,
        S_UP_RD,
        S_UP_WT,
        S_UP_WR,
        S_OUT
    } t_state;

endpackage

// ----- hw/rtl/bpa_tree_mem.sv -----
// bpa_tree_mem: dual-read, single-write synchronous RAM holding the
// largest-free-block value of every tree node. Depends on nothing else.
module bpa_tree_mem #(
    parameter int DEPTH  = 2048,
    parameter int AW     = 11,
    parameter int DW     = 11
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr_a,
    input  logic [AW-1:0] i_raddr_b,
    output logic [DW-1:0] o_rdata_a,
    output logic [DW-1:0] o_rdata_b
);

    logic [DW-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read ports
    always_ff @(posedge i_clk) begin
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

// ----- hw/rtl/buddy_page_allocator_core.sv -----
// buddy_page_allocator_core: top level; sequencer over the node RAM.
// Depends on bpa_pkg and bpa_tree_mem.
//
//  channel | direction | handshake          | payload
//  in      | in        | i_valid / o_stall  | i_opcode i_request_pages i_free_page
//  out     | out       | o_valid / i_stall  | o_status o_page_index o_free_count
//  cfg     | in        | i_cfg_we           | i_cfg_data (pool_log2)
//
// One operation at a time. An allocate walks down from the root to its node, then,
// like a free, back up to the root; every level walked costs one registered RAM
// read plus a decide or write-back step. A bad size is answered straight from the
// check state, a free rejected at its node once that node has been read.
// After reset or a pool_log2 write the RAM is rebuilt one node a cycle,
// 2*pool-1 nodes, while no item is taken. A result waits in the output
// register; the next item is taken once it is transferred.
module buddy_page_allocator_core #(
    parameter int MAX_PAGES = bpa_pkg::MAX_PAGES_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic                      i_opcode,
    input  logic [bpa_pkg::CNT_W-1:0] i_request_pages,
    input  logic [bpa_pkg::PAGE_W-1:0] i_free_page,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [1:0]                o_status,
    output logic [bpa_pkg::PAGE_W-1:0] o_page_index,
    output logic [bpa_pkg::CNT_W-1:0] o_free_count,
    input  logic                      i_cfg_we,
    input  logic [bpa_pkg::LOG_W-1:0] i_cfg_data
);

    localparam int MAXLOG = $clog2(MAX_PAGES + 1) - 1;
    localparam int DEPTH  = 2 << MAXLOG;
    localparam int AW     = MAXLOG + 1;
    localparam int W      = 18;          // wide enough for page math
    localparam int CW     = bpa_pkg::CNT_W;
    localparam int PW     = bpa_pkg::PAGE_W;
    localparam int LW     = bpa_pkg::LOG_W;

    bpa_pkg::t_state r_state, n_state;
    logic [bpa_pkg::LOG_W-1:0] r_log, n_log;
    logic [bpa_pkg::LOG_W-1:0] r_slog, n_slog;
    logic [W-1:0]  r_pool, n_pool;
    logic [W-1:0]  r_fcnt, n_fcnt;
    logic [AW-1:0] r_idx, n_idx;
    logic [W-1:0]  r_ns, n_ns;
    logic [W-1:0]  r_size, n_size;
    logic          r_op, n_op;
    logic [CW-1:0] r_req, n_req;
    logic [W-1:0]  r_base, n_base;
    logic          r_val, n_val;
    logic [1:0]    r_st, n_st;
    logic [bpa_pkg::PAGE_W-1:0] r_pg, n_pg;
    logic [W-1:0]  r_ins, n_ins;  // init node size

    logic          we;
    logic [AW-1:0] waddr, ra, rb;
    logic [CW-1:0] wdata, da, db;
    logic [W-1:0]  l, r, sum, rsize, lg_clamp_pool;
    logic [AW-1:0] par, fidx;
    logic [bpa_pkg::LOG_W-1:0] lg, rlog;

    bpa_tree_mem #(.DEPTH(DEPTH), .AW(AW), .DW(CW)) u_mem (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr_a(ra), .i_raddr_b(rb), .o_rdata_a(da), .o_rdata_b(db)
    );

    // round the request up to a power of two, keep its log2
    always_comb begin
        rsize = W'(1);
        rlog  = '0;
        for (int k = 0; k < CW; k++) begin
            if (rsize < W'(i_request_pages)) begin
                rsize = rsize << 1;
                rlog  = rlog + LW'(1);
            end
        end
    end

    // clamp configured log2
    always_comb begin
        lg = (i_cfg_data == '0) ? 4'd1 : i_cfg_data;
        if (lg > 4'(MAXLOG)) lg = 4'(MAXLOG);
        lg_clamp_pool = W'(1) << lg;
    end

    assign l   = W'(da);
    assign r   = W'(db);
    assign sum = l + r;
    assign par = AW'(((W'(r_idx) + W'(1)) >> 1) - W'(1));
    // node of a freed block: pool/size - 1 + base/size, all powers of two
    assign fidx = AW'(((W'(1) << (r_log - r_slog)) - W'(1)) + (r_base >> r_slog));

    assign o_stall      = (r_state != bpa_pkg::S_IDLE) || r_val;
    assign o_valid      = r_val;
    assign o_status     = r_st;
    assign o_page_index = r_pg;
    assign o_free_count = r_fcnt[CW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bpa_pkg::S_INIT;
            r_log   <= 4'(MAXLOG < 10 ? MAXLOG : 10);
            r_pool  <= W'(1) << (MAXLOG < 10 ? MAXLOG : 10);
            r_fcnt  <= W'(1) << (MAXLOG < 10 ? MAXLOG : 10);
            r_idx   <= '0;
            r_ins   <= W'(1) << (MAXLOG < 10 ? MAXLOG : 10);
            r_val   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_log   <= n_log;
            r_pool  <= n_pool;
            r_fcnt  <= n_fcnt;
            r_idx   <= n_idx;
            r_ins   <= n_ins;
            r_val   <= n_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ns   <= n_ns;
        r_size <= n_size;
        r_slog <= n_slog;
        r_op   <= n_op;
        r_req  <= n_req;
        r_base <= n_base;
        r_st   <= n_st;
        r_pg   <= n_pg;
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_log = r_log; n_pool = r_pool; n_fcnt = r_fcnt; n_idx = r_idx;
        n_ns = r_ns; n_size = r_size; n_slog = r_slog; n_op = r_op; n_req = r_req;
        n_base = r_base; n_val = r_val; n_st = r_st; n_pg = r_pg; n_ins = r_ins;
        we = 1'b0; waddr = r_idx; wdata = '0;
        ra = '0; rb = '0;
        if (r_val && !i_stall) n_val = 1'b0;
        case (r_state)
            bpa_pkg::S_INIT: begin
                // rebuild: node i holds its full subtree size
                we    = 1'b1;
                waddr = r_idx;
                wdata = CW'(r_ins);
                n_idx = r_idx + AW'(1);
                if (((W'(r_idx) + W'(2)) & (W'(r_idx) + W'(1))) == '0) n_ins = r_ins >> 1;
                if (W'(r_idx) == (r_pool << 1) - W'(2)) begin
                    n_state = bpa_pkg::S_IDLE;
                end
            end
            bpa_pkg::S_IDLE: begin
                if (i_valid && !o_stall) begin
                    n_op = i_opcode; n_req = i_request_pages;
                    n_base = W'(i_free_page); n_size = rsize; n_slog = rlog;
                    n_state = bpa_pkg::S_CHECK;
                end
                ra = '0;
            end
            bpa_pkg::S_CHECK: begin
                // da holds the root here
                n_pg = '0; n_st = bpa_pkg::ST_OK;
                n_ns = r_pool; n_idx = '0;
                if (r_req == '0 || r_size > r_pool) begin
                    n_st = bpa_pkg::ST_BAD_SIZE; n_state = bpa_pkg::S_OUT;
                end else if (r_op == bpa_pkg::OP_ALLOC) begin
                    if (W'(r_req) > r_fcnt || l < r_size) begin
                        n_st = bpa_pkg::ST_NO_SPACE; n_state = bpa_pkg::S_OUT;
                    end else begin
                        n_state = bpa_pkg::S_DOWN_RD;
                    end
                end else begin
                    if (r_base >= r_pool || (r_base & (r_size - W'(1))) != '0) begin
                        n_st = bpa_pkg::ST_BAD_FREE; n_state = bpa_pkg::S_OUT;
                    end else begin
                        n_state = bpa_pkg::S_FREE_RD;
                    end
                end
            end
            bpa_pkg::S_DOWN_RD: begin
                if (r_ns == r_size) begin
                    // mark used, page = (idx+1)*ns - pool
                    we = 1'b1; waddr = r_idx; wdata = '0;
                    n_pg = PW'(((W'(r_idx) + W'(1)) * r_ns) - r_pool);
                    n_fcnt = (r_fcnt >= r_size) ? r_fcnt - r_size : '0;
                    n_ns = r_size;
                    n_state = (r_idx == '0) ? bpa_pkg::S_OUT : bpa_pkg::S_UP_RD;
                end else begin
                    ra = AW'(2 * W'(r_idx) + W'(1));
                    rb = AW'(2 * W'(r_idx) + W'(2));
                    n_state = bpa_pkg::S_DOWN_DEC;
                end
            end
            bpa_pkg::S_DOWN_DEC: begin
                if (l >= r_size && r >= r_size)
                    n_idx = (l <= r) ? AW'(2 * W'(r_idx) + W'(1)) : AW'(2 * W'(r_idx) + W'(2));
                else
                    n_idx = (l < r) ? AW'(2 * W'(r_idx) + W'(2)) : AW'(2 * W'(r_idx) + W'(1));
                n_ns = r_ns >> 1;
                n_state = bpa_pkg::S_DOWN_RD;
            end
            bpa_pkg::S_FREE_RD: begin
                n_idx = fidx;
                ra = fidx;
                n_state = bpa_pkg::S_FREE_WT;
            end
            bpa_pkg::S_FREE_WT: begin
                if (l != '0) begin
                    n_st = bpa_pkg::ST_BAD_FREE; n_state = bpa_pkg::S_OUT;
                end else begin
                    we = 1'b1; waddr = r_idx; wdata = CW'(r_size);
                    n_ns = r_size;
                    n_fcnt = (r_fcnt + r_size > r_pool) ? r_pool : r_fcnt + r_size;
                    n_state = (r_idx == '0) ? bpa_pkg::S_OUT : bpa_pkg::S_UP_RD;
                end
            end
            bpa_pkg::S_UP_RD: begin
                // read both children of the parent
                n_idx = par;
                ra = AW'(2 * W'(par) + W'(1));
                rb = AW'(2 * W'(par) + W'(2));
                n_ns = r_ns << 1;
                n_state = bpa_pkg::S_UP_WR;
            end
            bpa_pkg::S_UP_WR: begin
                we = 1'b1; waddr = r_idx;
                if (r_op == bpa_pkg::OP_FREE && sum == r_ns) wdata = CW'(r_ns);
                else wdata = (l > r) ? CW'(l) : CW'(r);
                n_state = (r_idx == '0) ? bpa_pkg::S_OUT : bpa_pkg::S_UP_RD;
            end
            bpa_pkg::S_OUT: begin
                if (!r_val) begin
                    n_val = 1'b1;
                    n_state = bpa_pkg::S_IDLE;
                end
            end
            default: n_state = bpa_pkg::S_IDLE;
        endcase
        // configuration write reinitializes the tree
        if (i_cfg_we) begin
            n_log = lg; n_pool = lg_clamp_pool; n_fcnt = lg_clamp_pool;
            n_ins = lg_clamp_pool; n_idx = '0; n_state = bpa_pkg::S_INIT;
        end
    end

endmodule

// ----- verif/buddy_page_allocator_core_tb.sv -----
// buddy_page_allocator_core_tb: self-checking bench for the buddy page allocator core.
// Depends on bpa_pkg and buddy_page_allocator_core; drives random and directed
// alloc/free transfers and checks every result against an in-bench tree model.
`timescale 1ns / 100ps

module buddy_page_allocator_core_tb;

    localparam int CNT_W  = bpa_pkg::CNT_W;
    localparam int PAGE_W = bpa_pkg::PAGE_W;
    localparam int LOG_W  = bpa_pkg::LOG_W;
    localparam int NODES = 2 * bpa_pkg::MAX_PAGES_DEF;
    localparam int RAND_ITEMS = 500;

    typedef struct packed {
        logic              op;
        logic [CNT_W-1:0]  req;
        logic [PAGE_W-1:0] base;
    } t_request;

    typedef struct packed {
        logic [1:0]        status;
        logic [PAGE_W-1:0] page;
        logic [CNT_W-1:0]  count;
    } t_result;

    // directed row: request plus optional typed-in expectation
    typedef struct packed {
        t_request req;
        logic     has_exp;
        t_result  exp;
    } t_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic              i_opcode = bpa_pkg::OP_ALLOC;
    logic [CNT_W-1:0]  i_request_pages = '0;
    logic [PAGE_W-1:0] i_free_page = '0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic [1:0]        o_status;
    logic [PAGE_W-1:0] o_page_index;
    logic [CNT_W-1:0]  o_free_count;
    logic              i_cfg_we = 1'b0;
    logic [LOG_W-1:0]  i_cfg_data = '0;

    // allocator model state
    int unsigned tree_longest [NODES];
    int unsigned pages_free;
    int unsigned pool_pages;

    t_result  result_fifo[$];
    t_request live_blocks[$];
    int       fail_count = 0;
    bit       no_idle = 1'b0;
    bit       feeding = 1'b1;

    buddy_page_allocator_core DUT (.*);

    always #5 i_clk = ~i_clk;

    initial begin
        #50_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // rebuild the tree for a pool_log2 value
    function automatic void rebuild_pool(input int unsigned lg);
        int unsigned ns;
        if (lg < 1) lg = 1;
        if (lg > 10) lg = 10;
        pool_pages = 1 << lg;
        ns = pool_pages * 2;
        for (int unsigned i = 0; i < 2 * pool_pages - 1; i++) begin
            if (((i + 1) & i) == 0) ns = ns >> 1;
            tree_longest[i] = ns;
        end
        pages_free = pool_pages;
    endfunction

    function automatic void refresh_parents(input int unsigned idx, input int unsigned ns,
                                            input bit merge);
        int unsigned l, r;
        while (idx != 0) begin
            idx = (idx + 1) / 2 - 1;
            ns = ns << 1;
            l = tree_longest[2 * idx + 1];
            r = tree_longest[2 * idx + 2];
            if (merge && l + r == ns) tree_longest[idx] = ns;
            else tree_longest[idx] = (l > r) ? l : r;
        end
    endfunction

    // compute one result and advance the model
    function automatic t_result allocate_or_free(input t_request rq);
        t_result     res;
        int unsigned sz, idx, ns, li, ri, l, r;
        res = '0;
        sz = 1;
        while (sz < rq.req) sz = sz << 1;
        if (rq.req == 0 || sz > pool_pages) begin
            res.status = bpa_pkg::ST_BAD_SIZE;
        end else if (rq.op == bpa_pkg::OP_ALLOC) begin
            if (rq.req > pages_free || tree_longest[0] < sz) begin
                res.status = bpa_pkg::ST_NO_SPACE;
            end else begin
                idx = 0;
                ns = pool_pages;
                while (ns != sz) begin
                    li = 2 * idx + 1;
                    ri = 2 * idx + 2;
                    l = tree_longest[li];
                    r = tree_longest[ri];
                    if (l >= sz && r >= sz) idx = (l <= r) ? li : ri;
                    else idx = (l < r) ? ri : li;
                    ns = ns >> 1;
                end
                tree_longest[idx] = 0;
                res.page = PAGE_W'((idx + 1) * ns - pool_pages);
                refresh_parents(idx, ns, 1'b0);
                pages_free = (pages_free >= sz) ? pages_free - sz : 0;
            end
        end else begin
            if (rq.base >= pool_pages || (rq.base & (sz - 1)) != 0) begin
                res.status = bpa_pkg::ST_BAD_FREE;
            end else begin
                idx = pool_pages / sz - 1 + rq.base / sz;
                if (tree_longest[idx] != 0) begin
                    res.status = bpa_pkg::ST_BAD_FREE;
                end else begin
                    tree_longest[idx] = sz;
                    refresh_parents(idx, sz, 1'b1);
                    pages_free += sz;
                    if (pages_free > pool_pages) pages_free = pool_pages;
                end
            end
        end
        res.count = CNT_W'(pages_free);
        return res;
    endfunction

    // sink side: random stall bursts, check each transfer
    initial begin
        int burst;
        forever begin
            @(posedge i_clk);
            if (!no_idle && burst == 0 && $urandom_range(0, 7) == 0)
                burst = $urandom_range(1, 19);
            if (burst > 0) burst--;
            i_stall <= (burst > 0) && !no_idle;
        end
    end

    always @(posedge i_clk) begin
        t_result got, want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_status, o_page_index, o_free_count};
            if (result_fifo.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                fail_count++;
            end else begin
                want = result_fifo.pop_front();
                if (got.status !== want.status)
                    $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
                if (got.page !== want.page)
                    $display("%0t: page exp %0d got %0d", $time, want.page, got.page);
                if (got.count !== want.count)
                    $display("%0t: count exp %0d got %0d", $time, want.count, got.count);
                if (got !== want) fail_count++;
            end
        end
    end

    // send one request; check a typed-in expectation against the model
    task automatic send_request(input t_request rq, input bit has_exp, input t_result exp);
        t_result pred;
        if (!no_idle && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_opcode <= rq.op;
        i_request_pages <= rq.req;
        i_free_page <= rq.base;
        pred = allocate_or_free(rq);
        if (has_exp && pred !== exp) begin
            $display("%0t: table exp %h model %h", $time, exp, pred);
            fail_count++;
        end
        result_fifo.push_back(pred);
        if (rq.op == bpa_pkg::OP_ALLOC && pred.status == bpa_pkg::ST_OK)
            live_blocks.push_back('{bpa_pkg::OP_FREE, rq.req, pred.page});
        do @(posedge i_clk); while (o_stall);
    endtask

    // write pool_log2 once the block is drained and rebuild the model to match
    task automatic write_pool(input int unsigned lg);
        i_valid <= 1'b0;
        while (result_fifo.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= LOG_W'(lg);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        rebuild_pool(lg);
        live_blocks.delete();
    endtask

    function automatic t_request random_request();
        t_request    rq;
        int unsigned pick, k;
        pick = $urandom_range(0, 99);
        rq.base = PAGE_W'($urandom);
        if (pick < 45) begin
            rq.op = bpa_pkg::OP_ALLOC;
            rq.req = CNT_W'($urandom_range(1, pool_pages > 8 ? pool_pages / 4 : pool_pages));
        end else if (pick < 80 && live_blocks.size() != 0) begin
            k = $urandom_range(0, live_blocks.size() - 1);
            rq = live_blocks[k];
            live_blocks.delete(k);
        end else begin
            // noise: arbitrary fields, may be bad size or bad free
            rq.op = 1'($urandom);
            rq.req = $urandom_range(0, 3) == 0 ? CNT_W'($urandom)
                                               : CNT_W'($urandom_range(0, pool_pages));
            if (rq.op == bpa_pkg::OP_FREE && $urandom_range(0, 1)) begin
                k = 1;
                while (k < rq.req) k = k << 1;
                rq.base = PAGE_W'(($urandom_range(0, pool_pages) / k) * k);
            end
        end
        return rq;
    endfunction

    initial begin
        t_row rows [16] = '{
            '{'{bpa_pkg::OP_ALLOC, 11'd0,    10'd0},   1'b1,
              '{bpa_pkg::ST_BAD_SIZE, 10'd0, 11'd1024}},
            '{'{bpa_pkg::OP_ALLOC, 11'd1025, 10'd0},   1'b1,
              '{bpa_pkg::ST_BAD_SIZE, 10'd0, 11'd1024}},
            '{'{bpa_pkg::OP_ALLOC, 11'd2047, 10'd0},   1'b1,
              '{bpa_pkg::ST_BAD_SIZE, 10'd0, 11'd1024}},
            '{'{bpa_pkg::OP_ALLOC, 11'd1024, 10'd1023},1'b1,
              '{bpa_pkg::ST_OK,       10'd0, 11'd0}},
            '{'{bpa_pkg::OP_ALLOC, 11'd1,    10'd0},   1'b1,
              '{bpa_pkg::ST_NO_SPACE, 10'd0, 11'd0}},
            '{'{bpa_pkg::OP_FREE,  11'd1024, 10'd0},   1'b1,
              '{bpa_pkg::ST_OK,       10'd0, 11'd1024}},
            '{'{bpa_pkg::OP_FREE,  11'd1024, 10'd0},   1'b1,
              '{bpa_pkg::ST_BAD_FREE, 10'd0, 11'd1024}},
            '{'{bpa_pkg::OP_FREE,  11'd4,    10'd2},   1'b1,
              '{bpa_pkg::ST_BAD_FREE, 10'd0, 11'd1024}},
            '{'{bpa_pkg::OP_ALLOC, 11'd1,    10'd0},   1'b0, '0},
            '{'{bpa_pkg::OP_ALLOC, 11'd3,    10'd0},   1'b0, '0},
            '{'{bpa_pkg::OP_ALLOC, 11'd512,  10'd0},   1'b0, '0},
            '{'{bpa_pkg::OP_ALLOC, 11'd300,  10'd0},   1'b0, '0},
            '{'{bpa_pkg::OP_FREE,  11'd1,    10'd1023},1'b0, '0},
            '{'{bpa_pkg::OP_FREE,  11'd512,  10'd512}, 1'b0, '0},
            '{'{bpa_pkg::OP_FREE,  11'd1,    10'd0},   1'b0, '0},
            '{'{bpa_pkg::OP_FREE,  11'd2047, 10'd0},   1'b0, '0}
        };
        int unsigned cfgs [9] = '{1, 0, 15, 3, 10, 5, 12, 7, 10};
        rebuild_pool(10);
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[i]) send_request(rows[i].req, rows[i].has_exp, rows[i].exp);

        // random phases over several pool sizes, extremes included
        foreach (cfgs[c]) begin
            write_pool(cfgs[c]);
            if (c == $size(cfgs) - 1) no_idle = 1'b1;
            repeat (RAND_ITEMS / $size(cfgs)) send_request(random_request(), 1'b0, '0);
        end

        i_valid <= 1'b0;
        while (result_fifo.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (fail_count == 0 && result_fifo.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
